@@ rtl/grc_pkg.sv @@
// shared constants, types and command/status structs for the grid rectangle counter
package grc_pkg;

    localparam int MAX_DIM    = 256;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int BND_W      = DIM_W + 1;
    localparam int ADDR_W     = 2 * DIM_W;
    localparam int CNT_W      = 2 * DIM_W + 1;
    localparam int RS_W       = DIM_W + 1;
    localparam int NUM_TBL    = 3;
    localparam int TBL_CELL   = 0;
    localparam int TBL_HPAIR  = 1;
    localparam int TBL_VPAIR  = 2;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 2;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step Q_LAST = t_step'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LD_RD = 6'b000010,
        S_LD_WR = 6'b000100,
        S_Q_RD  = 6'b001000,
        S_Q_ACC = 6'b010000,
        S_Q_OUT = 6'b100000
    } t_state;

    typedef struct packed {
        logic  capture;
        logic  ld_read;
        logic  ld_write;
        logic  q_read;
        t_step q_step;
        logic  out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_is_query;
        logic in_err;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/grc_ram.sv @@
// generic single-port ram with registered read
module grc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ rtl/grc_ctrl.sv @@
// controller state machine sequencing loads and rectangle queries
module grc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  grc_pkg::t_dp_stat   i_stat,
    output grc_pkg::t_ctrl_cmd  o_cmd
);

    import grc_pkg::*;

    t_state r_state, n_state;
    t_step  r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_stat.in_is_query) begin
                        n_state = S_LD_RD;
                    end else if (i_stat.in_err) begin
                        n_state = S_Q_OUT;
                    end else begin
                        n_state = S_Q_RD;
                        n_step  = '0;
                    end
                end
            end
            S_LD_RD: begin
                o_cmd.ld_read = 1'b1;
                n_state       = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.ld_write = 1'b1;
                n_state        = S_IDLE;
            end
            S_Q_RD: begin
                o_cmd.q_read = 1'b1;
                o_cmd.q_step = r_step;
                n_step       = r_step + t_step'(1);
                if (r_step == Q_LAST) begin
                    n_state = S_Q_ACC;
                end
            end
            S_Q_ACC: begin
                n_state = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

@@ rtl/grc_datapath.sv @@
// datapath: config registers, load position, prefix tables, corner accumulation, result register
module grc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grc_pkg::t_ctrl_cmd             i_cmd,
    output grc_pkg::t_dp_stat              o_stat,
    input  logic                           i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grc_pkg::BND_W-1:0]      i_cfg_data,
    input  logic                           i_req_type,
    input  logic                           i_cell_bit,
    input  logic [grc_pkg::BND_W-1:0]      i_row_low,
    input  logic [grc_pkg::BND_W-1:0]      i_col_low,
    input  logic [grc_pkg::BND_W-1:0]      i_row_high,
    input  logic [grc_pkg::BND_W-1:0]      i_col_high,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [grc_pkg::CNT_W-1:0]      o_component_count,
    output logic                           o_query_error
);

    import grc_pkg::*;

    function automatic logic [BND_W-1:0] clamp_dim(input logic [BND_W-1:0] v);
        logic [BND_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = BND_W'(1);
        end else if (v > BND_W'(MAX_DIM)) begin
            res = BND_W'(MAX_DIM);
        end
        return res;
    endfunction

    logic [BND_W-1:0]  r_grid_rows, r_grid_cols;
    logic [DIM_W-1:0]  r_load_row, r_load_col;
    logic              r_grid_loaded;
    logic              r_left;
    logic              r_bit;
    logic [BND_W-1:0]  r_rl, r_cl, r_rh, r_ch;
    logic              r_q_err;
    logic [RS_W-1:0]   r_rs [NUM_TBL];
    logic [CNT_W-1:0]  r_acc [NUM_TBL];
    logic              r_rd_vld;
    t_step             r_rd_step;
    logic [NUM_TBL-1:0] r_rd_zero;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic              r_err;

    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_addr  [NUM_TBL];
    logic [CNT_W-1:0]  tbl_wdata [NUM_TBL];
    logic [CNT_W-1:0]  tbl_rdata [NUM_TBL];
    logic              abv_rdata;

    logic              in_err;
    logic              out_free;
    logic              row_nz, col_nz;
    logic              up_bit, left_bit;
    logic [NUM_TBL-1:0] inc;
    logic [RS_W-1:0]   rs_new [NUM_TBL];
    logic [BND_W-1:0]  rlo [NUM_TBL];
    logic [BND_W-1:0]  clo [NUM_TBL];
    logic [BND_W-1:0]  cr  [NUM_TBL];
    logic [BND_W-1:0]  cc  [NUM_TBL];
    logic [BND_W-1:0]  rm1 [NUM_TBL];
    logic [BND_W-1:0]  cm1 [NUM_TBL];
    logic [NUM_TBL-1:0] q_zero;
    logic [DIM_W-1:0]  ld_up_row;
    logic [BND_W-1:0]  col_inc, row_inc;
    logic [CNT_W:0]    cells_x, pairs, diff;
    logic [CNT_W-1:0]  count;

    // error check straight off the input ports, taken at the accepting edge
    assign in_err = !r_grid_loaded || (i_row_low == '0) || (i_col_low == '0)
                    || (i_row_low > i_row_high) || (i_col_low > i_col_high)
                    || (i_row_high > r_grid_rows) || (i_col_high > r_grid_cols);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.in_is_query = i_req_type;
    assign o_stat.in_err      = in_err;
    assign o_stat.out_free    = out_free;

    // load side
    assign row_nz    = (r_load_row != '0);
    assign col_nz    = (r_load_col != '0);
    assign up_bit    = row_nz & abv_rdata;
    assign left_bit  = col_nz & r_left;
    assign inc[TBL_CELL]  = r_bit;
    assign inc[TBL_HPAIR] = r_bit & left_bit;
    assign inc[TBL_VPAIR] = r_bit & up_bit;
    assign ld_up_row = r_load_row - DIM_W'(1);
    assign col_inc   = {1'b0, r_load_col} + BND_W'(1);
    assign row_inc   = {1'b0, r_load_row} + BND_W'(1);

    // per-table lower corners of the rectangle
    assign rlo[TBL_CELL]  = r_rl - BND_W'(1);
    assign rlo[TBL_HPAIR] = r_rl - BND_W'(1);
    assign rlo[TBL_VPAIR] = r_rl;
    assign clo[TBL_CELL]  = r_cl - BND_W'(1);
    assign clo[TBL_HPAIR] = r_cl;
    assign clo[TBL_VPAIR] = r_cl - BND_W'(1);

    assign tbl_we = i_cmd.ld_write;

    for (genvar t = 0; t < NUM_TBL; t++) begin : g_tbl
        assign rs_new[t] = (col_nz ? r_rs[t] : '0) + RS_W'(inc[t]);
        assign tbl_wdata[t] = (row_nz ? tbl_rdata[t] : '0) + CNT_W'(rs_new[t]);

        assign cr[t]     = i_cmd.q_step[0] ? rlo[t] : r_rh;
        assign cc[t]     = i_cmd.q_step[1] ? clo[t] : r_ch;
        assign q_zero[t] = (cr[t] == '0) || (cc[t] == '0);
        assign rm1[t]    = cr[t] - BND_W'(1);
        assign cm1[t]    = cc[t] - BND_W'(1);

        always_comb begin
            if (i_cmd.q_read) begin
                tbl_addr[t] = {rm1[t][DIM_W-1:0], cm1[t][DIM_W-1:0]};
            end else if (i_cmd.ld_read) begin
                tbl_addr[t] = {ld_up_row, r_load_col};
            end else begin
                tbl_addr[t] = {r_load_row, r_load_col};
            end
        end

        grc_ram #(
            .WIDTH (CNT_W),
            .DEPTH (MAX_DIM * MAX_DIM)
        ) u_tbl (
            .i_clk   (i_clk),
            .i_we    (tbl_we),
            .i_addr  (tbl_addr[t]),
            .i_wdata (tbl_wdata[t]),
            .o_rdata (tbl_rdata[t])
        );

        always_ff @(posedge i_clk) begin
            if (i_cmd.ld_write) begin
                r_rs[t] <= rs_new[t];
            end
            if (i_cmd.capture) begin
                r_acc[t] <= '0;
            end else if (r_rd_vld) begin
                if (r_rd_step[0] == r_rd_step[1]) begin
                    r_acc[t] <= r_acc[t] + (r_rd_zero[t] ? '0 : tbl_rdata[t]);
                end else begin
                    r_acc[t] <= r_acc[t] - (r_rd_zero[t] ? '0 : tbl_rdata[t]);
                end
            end
        end
    end

    grc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DIM)
    ) u_above (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_write),
        .i_addr  (r_load_col),
        .i_wdata (r_bit),
        .o_rdata (abv_rdata)
    );

    // final combine: cells minus pairs, floored at zero
    assign cells_x = {1'b0, r_acc[TBL_CELL]};
    assign pairs   = {1'b0, r_acc[TBL_HPAIR]} + {1'b0, r_acc[TBL_VPAIR]};
    assign diff    = cells_x - pairs;
    assign count   = (cells_x > pairs) ? diff[CNT_W-1:0] : '0;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows   <= clamp_dim(BND_W'(MAX_DIM));
            r_grid_cols   <= clamp_dim(BND_W'(MAX_DIM));
            r_load_row    <= '0;
            r_load_col    <= '0;
            r_grid_loaded <= 1'b0;
            r_left        <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.q_read;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == CFG_GRID_ROWS || i_cfg_index == CFG_GRID_COLS)) begin
                if (i_cfg_index == CFG_GRID_ROWS) begin
                    r_grid_rows <= clamp_dim(i_cfg_data);
                end else begin
                    r_grid_cols <= clamp_dim(i_cfg_data);
                end
                r_load_row    <= '0;
                r_load_col    <= '0;
                r_grid_loaded <= 1'b0;
                r_left        <= 1'b0;
            end else if (i_cmd.capture && !i_req_type && r_grid_loaded) begin
                // new grid after a complete one
                r_load_row    <= '0;
                r_load_col    <= '0;
                r_grid_loaded <= 1'b0;
                r_left        <= 1'b0;
            end else if (i_cmd.ld_write) begin
                r_left <= r_bit;
                if (col_inc >= r_grid_cols) begin
                    r_load_col <= '0;
                    if (row_inc >= r_grid_rows) begin
                        r_load_row    <= '0;
                        r_grid_loaded <= 1'b1;
                    end else begin
                        r_load_row <= row_inc[DIM_W-1:0];
                    end
                end else begin
                    r_load_col <= col_inc[DIM_W-1:0];
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bit   <= i_cell_bit;
            r_rl    <= i_row_low;
            r_cl    <= i_col_low;
            r_rh    <= i_row_high;
            r_ch    <= i_col_high;
            r_q_err <= in_err;
        end
        if (i_cmd.q_read) begin
            r_rd_step <= i_cmd.q_step;
            r_rd_zero <= q_zero;
        end
        if (i_cmd.out_load) begin
            r_count <= r_q_err ? '0 : count;
            r_err   <= r_q_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_component_count = r_count;
    assign o_query_error     = r_err;

endmodule

@@ rtl/grid_rect_component_counter.sv @@
// top level of the grid rectangle component counter
//
// input channel (i_in_valid/o_in_ready): one transfer is either a load of the
// next grid cell in row-major order or a rectangle query. loads give no result.
// output channel (o_out_valid/i_out_ready): one result per query, count and error.
// config channel (i_cfg_valid/o_cfg_ready): index 0 rows, 1 columns; always
// ready; a write restarts grid loading. write only while the block is idle.
// a load passes through the transfer, one table read and one table write.
// a query does four corner reads from each of three single-port prefix
// tables, then finishes the sum, then registers the result; a rejected
// query goes from the transfer straight to the result register.
// the output register lets loads proceed while a result waits; a query whose
// result is ready holds while the previous one has not been taken.
// reset clears control state and sets rows and columns to 256; the prefix
// tables need no clearing, a query before a complete load reports an error.
module grid_rect_component_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grc_pkg::BND_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic                           i_cell_bit,
    input  logic [grc_pkg::BND_W-1:0]      i_row_low,
    input  logic [grc_pkg::BND_W-1:0]      i_col_low,
    input  logic [grc_pkg::BND_W-1:0]      i_row_high,
    input  logic [grc_pkg::BND_W-1:0]      i_col_high,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [grc_pkg::CNT_W-1:0]      o_component_count,
    output logic                           o_query_error
);

    import grc_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    assign o_cfg_ready = 1'b1;

    grc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    grc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_valid & o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_cell_bit        (i_cell_bit),
        .i_row_low         (i_row_low),
        .i_col_low         (i_col_low),
        .i_row_high        (i_row_high),
        .i_col_high        (i_col_high),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_component_count (o_component_count),
        .o_query_error     (o_query_error)
    );

endmodule

@@ rtl/grc_checker.sv @@
// port-level checker for the grid rectangle component counter, bound to the top level
module grc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [grc_pkg::CNT_W-1:0]      o_component_count,
    input logic                           o_query_error
);

    // one item at a time: no input transfer in the cycle after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // a new result comes from query work, never straight from idle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without preceding work");

    a_error_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_query_error) |-> (o_component_count == '0))
        else $error("error result with nonzero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_component_count) && $stable(o_query_error)))
        else $error("stalled result dropped or changed");

endmodule

bind grid_rect_component_counter grc_checker u_grc_checker (.*);

@@ tb/sv/grid_rect_component_counter_tb.sv @@
// testbench for the grid rectangle component counter: prefix-sum scoreboard, drivers and checks
module grid_rect_component_counter_tb;
    import grc_pkg::*;

    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_QUERY     = 1'b1;
    localparam int   TOTAL_ITEMS   = 1870;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   CYCLE_LIMIT   = 1000000;

    class grid_count_scoreboard;
        typedef struct packed {
            logic [CNT_W-1:0] count;
            logic             err;
        } answer_t;

        int unsigned rows_used;
        int unsigned cols_used;
        int unsigned next_row;
        int unsigned next_col;
        bit          grid_done;
        bit          prev_bit;
        bit          upper_bits[MAX_DIM];
        int unsigned prefix_tbl[NUM_TBL][MAX_DIM][MAX_DIM];
        answer_t     pending_q[$];
        int          errors;

        function new();
            rows_used = MAX_DIM;
            cols_used = MAX_DIM;
            errors    = 0;
            foreach (upper_bits[i]) upper_bits[i] = 1'b0;
            restart_pass();
        endfunction

        function void restart_pass();
            next_row  = 0;
            next_col  = 0;
            grid_done = 1'b0;
            prev_bit  = 1'b0;
        endfunction

        function int unsigned fit_dim(logic [BND_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        // prefix over the first r rows and c columns
        function int unsigned corner(int t, int unsigned r, int unsigned c);
            if (r == 0 || c == 0 || r > MAX_DIM || c > MAX_DIM) return 0;
            return prefix_tbl[t][r-1][c-1];
        endfunction

        function int unsigned area_sum(int t, int unsigned r0, int unsigned r1,
                                       int unsigned c0, int unsigned c1);
            return corner(t, r1, c1) - corner(t, r0, c1) - corner(t, r1, c0)
                   + corner(t, r0, c0);
        endfunction

        function void add_entry(int t, int unsigned r, int unsigned c, int unsigned inc);
            prefix_tbl[t][r][c] = inc + corner(t, r, c + 1) + corner(t, r + 1, c)
                                  - corner(t, r, c);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [BND_W-1:0] v);
            if (idx == CFG_GRID_ROWS) begin
                rows_used = fit_dim(v);
                restart_pass();
            end else if (idx == CFG_GRID_COLS) begin
                cols_used = fit_dim(v);
                restart_pass();
            end
        endfunction

        function void note_input(logic req, logic cbit, int unsigned rl, int unsigned cl,
                                 int unsigned rh, int unsigned ch);
            int unsigned r;
            int unsigned c;
            int unsigned left_in;
            int unsigned up_in;
            int unsigned cells;
            int unsigned pairs;
            answer_t     ans;
            if (req == REQ_LOAD) begin
                if (grid_done) restart_pass();
                r       = next_row;
                c       = next_col;
                left_in = (c > 0) ? prev_bit : 0;
                up_in   = (r > 0) ? upper_bits[c] : 0;
                add_entry(TBL_CELL, r, c, cbit);
                add_entry(TBL_HPAIR, r, c, cbit & left_in);
                add_entry(TBL_VPAIR, r, c, cbit & up_in);
                upper_bits[c] = cbit;
                prev_bit      = cbit;
                c++;
                if (c >= cols_used) begin
                    c = 0;
                    r++;
                    if (r >= rows_used) begin
                        r         = 0;
                        grid_done = 1'b1;
                    end
                end
                next_row = r;
                next_col = c;
            end else begin
                ans.count = '0;
                ans.err   = 1'b1;
                if (grid_done && rl != 0 && cl != 0 && rl <= rh && cl <= ch &&
                    rh <= rows_used && ch <= cols_used) begin
                    cells = area_sum(TBL_CELL, rl - 1, rh, cl - 1, ch);
                    pairs = area_sum(TBL_HPAIR, rl - 1, rh, cl, ch)
                            + area_sum(TBL_VPAIR, rl, rh, cl - 1, ch);
                    ans.count = (cells > pairs) ? CNT_W'(cells - pairs) : '0;
                    ans.err   = 1'b0;
                end
                pending_q.push_back(ans);
            end
        endfunction

        task report(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
            errors++;
        endtask

        task check_result(logic [CNT_W-1:0] count, logic err);
            answer_t want;
            if (pending_q.size() == 0) begin
                report("unexpected result, component_count", '0, count);
                return;
            end
            want = pending_q.pop_front();
            if (count !== want.count) report("component_count", want.count, count);
            if (err !== want.err) report("query_error", want.err, err);
        endtask
    endclass

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_valid       = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index       = '0;
    logic [BND_W-1:0]     i_cfg_data        = '0;
    logic                 i_in_valid        = 1'b0;
    logic                 o_in_ready;
    logic                 i_req_type        = 1'b0;
    logic                 i_cell_bit        = 1'b0;
    logic [BND_W-1:0]     i_row_low         = '0;
    logic [BND_W-1:0]     i_col_low         = '0;
    logic [BND_W-1:0]     i_row_high        = '0;
    logic [BND_W-1:0]     i_col_high        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready       = 1'b0;
    logic [CNT_W-1:0]     o_component_count;
    logic                 o_query_error;

    grid_count_scoreboard sb;
    bit                   in_idle     = 1'b1;
    bit                   out_idle    = 1'b1;
    int                   items_sent  = 0;
    int                   cycle_count = 0;
    int                   ready_hold  = 0;
    int                   next_hold;
    int                   rows_now;
    int                   cols_now;

    grid_rect_component_counter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_cell_bit        (i_cell_bit),
        .i_row_low         (i_row_low),
        .i_col_low         (i_col_low),
        .i_row_high        (i_row_high),
        .i_col_high        (i_col_high),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_component_count (o_component_count),
        .o_query_error     (o_query_error)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_rect_component_counter regression: fail");
            $finish;
        end
    end

    // input and config transfers feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) sb.note_config(i_cfg_index, i_cfg_data);
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_input(i_req_type, i_cell_bit, i_row_low, i_col_low, i_row_high, i_col_high);
        end
    end

    // result side: check each transfer, then stall at random when out_idle is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_hold  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            sb.check_result(o_component_count, o_query_error);
            next_hold = out_idle ? $urandom_range(0, 7) : 0;
            ready_hold  <= next_hold;
            i_out_ready <= (next_hold == 0);
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            if (ready_hold == 1) i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic req, logic cbit, logic [BND_W-1:0] rl,
                             logic [BND_W-1:0] cl, logic [BND_W-1:0] rh,
                             logic [BND_W-1:0] ch);
        int gap;
        gap = in_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_cell_bit <= cbit;
        i_row_low  <= rl;
        i_col_low  <= cl;
        i_row_high <= rh;
        i_col_high <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_query(int rl, int cl, int rh, int ch);
        send_item(REQ_QUERY, 1'($urandom_range(0, 1)), BND_W'(rl), BND_W'(cl),
                  BND_W'(rh), BND_W'(ch));
    endtask

    // bounds fields are don't-care on a load and get random content
    task automatic load_cells(int n, int density);
        repeat (n) begin
            send_item(REQ_LOAD, ($urandom_range(0, 99) < density),
                      BND_W'($urandom_range(0, 511)), BND_W'($urandom_range(0, 511)),
                      BND_W'($urandom_range(0, 511)), BND_W'($urandom_range(0, 511)));
        end
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [BND_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register code for a dimension, using the clamped encodings at the extremes
    function automatic logic [BND_W-1:0] dim_code(int dim);
        int pick;
        pick = $urandom_range(0, 2);
        if (dim == 1 && pick == 0) return '0;
        if (dim == MAX_DIM && pick == 1) return 9'd511;
        if (dim == MAX_DIM && pick == 2) return BND_W'($urandom_range(MAX_DIM + 1, 510));
        return BND_W'(dim);
    endfunction

    task automatic random_query();
        int pick;
        int rl;
        int cl;
        int rh;
        int ch;
        pick = $urandom_range(0, 9);
        rl = $urandom_range(1, rows_now);
        rh = $urandom_range(rl, rows_now);
        cl = $urandom_range(1, cols_now);
        ch = $urandom_range(cl, cols_now);
        if (pick == 7) begin
            if ($urandom_range(0, 1)) send_query(1, 1, rows_now, cols_now);
            else send_query(rows_now, cols_now, rows_now, cols_now);
        end else if (pick == 8) begin
            case ($urandom_range(0, 4))
                0: rl = 0;
                1: cl = 0;
                2: rh = rows_now + $urandom_range(1, 3);
                3: ch = cols_now + $urandom_range(1, 3);
                default: rl = rh + 1;
            endcase
            send_query(rl, cl, rh, ch);
        end else if (pick == 9) begin
            send_query($urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 511), $urandom_range(0, 511));
        end else begin
            send_query(rl, cl, rh, ch);
        end
    endtask

    initial begin
        int shape;
        int density;
        int cells_total;
        int part;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: query before load, partial load, saturation, bad bounds, reload
        send_query(1, 1, 1, 1);
        wait_quiet();
        cfg_write(CFG_GRID_ROWS, 9'd3);
        cfg_write(CFG_GRID_COLS, 9'd3);
        rows_now = 3;
        cols_now = 3;
        load_cells(4, 100);
        send_query(1, 1, 3, 3);
        load_cells(5, 100);
        send_query(1, 1, 3, 3);
        send_query(2, 2, 2, 2);
        send_query(1, 1, 1, 3);
        send_query(0, 1, 1, 1);
        send_query(1, 0, 1, 1);
        send_query(3, 1, 2, 1);
        send_query(1, 3, 1, 2);
        send_query(1, 1, 4, 3);
        send_query(1, 1, 3, 256);
        send_query(511, 511, 511, 511);
        wait_quiet();
        load_cells(1, 0);
        send_query(1, 1, 1, 1);

        while (items_sent < TOTAL_ITEMS) begin
            wait_quiet();
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            shape    = $urandom_range(0, 11);
            if (shape == 0) begin
                rows_now = MAX_DIM;
                cols_now = 1;
            end else if (shape == 1) begin
                rows_now = 1;
                cols_now = MAX_DIM;
            end else if (shape < 5) begin
                rows_now = $urandom_range(1, 16);
                cols_now = $urandom_range(1, 16);
            end else begin
                rows_now = $urandom_range(1, 6);
                cols_now = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 1)) begin
                cfg_write(CFG_GRID_ROWS, dim_code(rows_now));
                cfg_write(CFG_GRID_COLS, dim_code(cols_now));
            end else begin
                cfg_write(CFG_GRID_COLS, dim_code(cols_now));
                cfg_write(CFG_GRID_ROWS, dim_code(rows_now));
            end
            density     = $urandom_range(0, 100);
            cells_total = rows_now * cols_now;
            repeat ($urandom_range(0, 2)) random_query();
            if ($urandom_range(0, 7) == 0 && cells_total > 1) begin
                // abandoned load: queries must keep failing
                load_cells($urandom_range(1, cells_total - 1), density);
                repeat ($urandom_range(1, 3)) random_query();
            end else begin
                load_cells(cells_total, density);
                repeat ($urandom_range(6, 24)) random_query();
                if ($urandom_range(0, 4) == 0) begin
                    // load after a complete grid starts a new one
                    density = $urandom_range(0, 100);
                    part    = $urandom_range(1, cells_total);
                    load_cells(part, density);
                    if (part < cells_total) begin
                        random_query();
                        load_cells(cells_total - part, density);
                    end
                    repeat ($urandom_range(4, 16)) random_query();
                end
            end
        end

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("grid_rect_component_counter regression: pass");
        end else begin
            $display("grid_rect_component_counter regression: fail");
        end
        $finish;
    end
endmodule
